// File: hw/rtl/raa_pkg.sv
// Shared types and constants of the region arena allocator.
// No dependencies; imported by the allocator top level and its checker.
package raa_pkg;

  // Width of a stored fill level and of the capacity register.
  localparam int FILL_W = 17;

  // Saturation value of a fill level.
  localparam logic [FILL_W-1:0] FILL_MAX = 17'h1FFFF;

  // Region capacity after reset, in bytes.
  localparam logic [FILL_W-1:0] CAP_RESET = 17'd4096;

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_REWIND = 2'd1,
    OP_RESET  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // Status codes of a result transaction.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NO_REGION = 2'd2
  } status_t;

endpackage

// File: hw/rtl/raa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the per-region fill levels of the allocator.
module raa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/region_arena_allocator_unit.sv
// Region arena allocator: bump allocation over equal regions with rewind.
// A result is registered from the lookup state, which holds the RAM read,
// or from the advance state when an allocate during rewind moves to the next
// region (second RAM read). One transaction is taken at a time, through the
// read-modify-write of the fill-level RAM; a stalled output holds the lookup.
// Reset (rst, synchronous): one empty region, no rewind, capacity 4096 bytes.
module region_arena_allocator_unit #(
  parameter int MAX_REGIONS = 16,
  parameter int OFFSET_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write_enable,
  input  logic [raa_pkg::FILL_W-1:0] cfg_write_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              opcode,
  input  logic [16:0]             request_size,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic [3:0]              region_index,
  output logic [15:0]             byte_offset,
  output logic [4:0]              regions_in_use
);
  import raa_pkg::*;

  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [32:0] CAP_LIMIT = 33'(1) << OFFSET_BITS;
  localparam logic [32:0] OFS_MASK  = CAP_LIMIT - 33'd1;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_LOOKUP  = 3'b010,
    S_ADVANCE = 3'b100
  } state_t;

  state_t                 state;
  logic [1:0]             op_q;
  logic [FILL_W-1:0]      size_q;
  logic [IDX_W-1:0]       cur_idx;
  logic                   rd_valid;
  logic [CNT_W-1:0]       region_count;
  logic                   rewind_active;
  logic [IDX_W-1:0]       rewind_pos;
  logic [MAX_REGIONS-1:0] valid_bits;
  logic [FILL_W-1:0]      capacity;

  logic                   in_fire;
  logic                   out_free;
  logic [FILL_W-1:0]      eff_cap;
  logic [IDX_W-1:0]       tail_idx;
  logic [IDX_W-1:0]       lookup_idx;
  logic [IDX_W-1:0]       new_idx;
  logic [IDX_W-1:0]       adv_idx;
  logic [CNT_W-1:0]       pos_inc;
  logic                   adv_stop;
  logic                   at_limit;
  logic [FILL_W-1:0]      ram_rdata;
  logic [FILL_W-1:0]      used;
  logic [FILL_W:0]        sum;
  logic                   fits;
  logic                   size_bad;
  logic [FILL_W-1:0]      sat_fill;

  status_t                res_status;
  logic [IDX_W-1:0]       res_idx;
  logic [FILL_W-1:0]      res_fill;
  logic [CNT_W-1:0]       res_count;
  logic                   grow;
  logic                   go_adv;
  logic                   load_out;
  logic                   clear_fill;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [FILL_W-1:0]      ram_wdata;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign out_free = !out_valid || out_ready;

  // Capacity clamped to the offset range.
  assign eff_cap = (33'(capacity) > CAP_LIMIT) ? CAP_LIMIT[FILL_W-1:0] : capacity;

  // Region selection: tail, rewind position, next region and the rewind step.
  assign tail_idx   = IDX_W'(region_count - CNT_W'(1));
  assign lookup_idx = rewind_active ? rewind_pos : tail_idx;
  assign new_idx    = IDX_W'(region_count);
  assign pos_inc    = CNT_W'(rewind_pos) + CNT_W'(1);
  assign adv_stop   = (pos_inc >= region_count - CNT_W'(1));
  assign adv_idx    = adv_stop ? tail_idx : IDX_W'(pos_inc);
  assign at_limit   = (region_count >= CNT_W'(MAX_REGIONS));

  // Fit check on the fill level read from the RAM; a cleared entry reads zero.
  assign used     = rd_valid ? ram_rdata : '0;
  assign sum      = {1'b0, used} + {1'b0, size_q};
  assign fits     = (sum <= {1'b0, eff_cap});
  assign size_bad = (size_q == '0) || (size_q > eff_cap);
  assign sat_fill = sum[FILL_W] ? FILL_MAX : sum[FILL_W-1:0];

  // Result of the transaction in its lookup or advance step.
  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    res_fill   = '0;
    res_count  = region_count;
    grow       = 1'b0;
    go_adv     = 1'b0;
    clear_fill = 1'b0;
    case (state)
      S_LOOKUP: begin
        case (op_q)
          OP_ALLOC: begin
            if (size_bad) begin
              res_status = ST_BAD_SIZE;
            end else if (fits) begin
              res_idx  = cur_idx;
              res_fill = used;
            end else if (!rewind_active) begin
              if (at_limit) begin
                res_status = ST_NO_REGION;
              end else begin
                grow      = 1'b1;
                res_idx   = new_idx;
                res_count = region_count + CNT_W'(1);
              end
            end else begin
              go_adv = 1'b1;
            end
          end
          OP_REWIND: begin
            clear_fill = 1'b1;
          end
          OP_RESET: begin
            clear_fill = 1'b1;
            res_count  = CNT_W'(1);
          end
          default: begin
          end
        endcase
      end
      S_ADVANCE: begin
        res_idx  = cur_idx;
        res_fill = used;
      end
      default: begin
      end
    endcase
  end

  assign load_out = out_free && (((state == S_LOOKUP) && !go_adv) || (state == S_ADVANCE));

  // Fill-level RAM access: lookup read at acceptance, a second read on a
  // rewind move, and the write-back of the new fill level.
  assign ram_re    = in_fire || (out_free && go_adv);
  assign ram_raddr = in_fire ? lookup_idx : adv_idx;
  assign ram_we    = out_free &&
                     (((state == S_LOOKUP) && (op_q == OP_ALLOC) && !size_bad &&
                       (fits || grow)) || (state == S_ADVANCE));
  assign ram_waddr = grow ? new_idx : cur_idx;
  assign ram_wdata = grow ? size_q : sat_fill;

  raa_ram #(
    .WIDTH(FILL_W),
    .DEPTH(MAX_REGIONS)
  ) u_fill_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write_enable) begin
      capacity <= cfg_write_data;
    end
  end

  // Sequencer and allocator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      region_count  <= CNT_W'(1);
      rewind_active <= 1'b0;
      rewind_pos    <= '0;
      valid_bits    <= '0;
      rd_valid      <= 1'b0;
    end else begin
      if (ram_re) begin
        rd_valid <= valid_bits[ram_raddr];
      end
      if (clear_fill && out_free) begin
        valid_bits <= '0;
      end else if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (out_free) begin
            region_count <= res_count;
            if (go_adv) begin
              state      <= S_ADVANCE;
              rewind_pos <= adv_idx;
              if (adv_stop) begin
                rewind_active <= 1'b0;
              end
            end else begin
              state <= S_IDLE;
            end
            if (op_q == OP_REWIND) begin
              if (region_count > CNT_W'(1)) begin
                rewind_active <= 1'b1;
                rewind_pos    <= '0;
              end
            end else if (op_q == OP_RESET) begin
              rewind_active <= 1'b0;
              rewind_pos    <= '0;
            end
          end
        end
        S_ADVANCE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Input capture and the region chosen for the lookup.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q    <= opcode;
      size_q  <= request_size;
      cur_idx <= lookup_idx;
    end else if (out_free && go_adv) begin
      cur_idx <= adv_idx;
    end
  end

  // Output register: a result waits here while the next transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status         <= res_status;
      region_index   <= 4'(res_idx);
      byte_offset    <= res_fill[15:0] & OFS_MASK[15:0];
      regions_in_use <= 5'(res_count);
    end
  end

endmodule

// File: hw/rtl/raa_checker.sv
// Port-level checker for the region arena allocator, bound to its top level.
// Depends on raa_pkg for the status codes.
module raa_checker #(
  parameter int MAX_REGIONS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [3:0]  region_index,
  input logic [15:0] byte_offset,
  input logic [4:0]  regions_in_use
);
  import raa_pkg::*;

  // A failed result carries no placement.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (region_index == 4'd0) && (byte_offset == 16'd0))
    else $error("failed transaction reports a placement");

  // Running out of regions happens only with every region open.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_REGION) |-> (regions_in_use == 5'(MAX_REGIONS)))
    else $error("no-region status with regions still free");

  // One transaction at a time: input is not ready right after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(region_index) &&
      $stable(byte_offset) && $stable(regions_in_use))
    else $error("stalled result changed");

endmodule

bind region_arena_allocator_unit raa_checker #(.MAX_REGIONS(MAX_REGIONS)) u_raa_checker (.*);
